FILE: sv/vre_pkg.sv
// ----------------------------------------------------------------------------
// vre_pkg
// Shared types, constants and the CRC-32 byte update for the voxel run-length
// encoder.
// ----------------------------------------------------------------------------
package vre_pkg;

  localparam int unsigned MAX_VOXELS = 65536;
  localparam int unsigned VCNT_W     = $clog2(MAX_VOXELS + 1);
  localparam int unsigned POS_W      = 18;
  localparam int unsigned RUN_W      = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [RUN_W-1:0] RUN_TOP  = 16'hFFFF;
  localparam logic [31:0]      CRC_POLY = 32'hEDB88320;
  localparam logic [31:0]      CRC_ONES = 32'hFFFFFFFF;

  localparam logic [7:0] MAGIC [4] = '{8'h56, 8'h43, 8'h48, 8'h4B};

  // Byte steps of one queue entry: header, split record, final record, CRC
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_HDR      = 5'd0;
  localparam logic [STEP_W-1:0] STEP_VERSION  = 5'd4;
  localparam logic [STEP_W-1:0] STEP_FLAGS    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_HDR_CRC  = 5'd7;
  localparam logic [STEP_W-1:0] STEP_HDR_END  = 5'd11;
  localparam logic [STEP_W-1:0] STEP_BRK      = 5'd12;
  localparam logic [STEP_W-1:0] STEP_BRK_END  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_FIN      = 5'd15;
  localparam logic [STEP_W-1:0] STEP_PATCH    = 5'd18;
  localparam logic [STEP_W-1:0] STEP_END      = 5'd21;

  localparam logic [POS_W-1:0] PATCH_BASE = 18'd8;

  localparam logic [0:0] REG_EDITED  = 1'b0;
  localparam logic [0:0] REG_VERSION = 1'b1;

  typedef struct packed {
    logic             hdr;
    logic [7:0]       version;
    logic             edited;
    logic             brk;
    logic [7:0]       brk_sym;
    logic [RUN_W-1:0] brk_len;
    logic             fin;
    logic [7:0]       fin_sym;
    logic [RUN_W-1:0] fin_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/vre_front.sv
// ----------------------------------------------------------------------------
// vre_front
// Accepts voxels, tracks the open run and chunk, and queues one command per
// voxel that has bytes to emit (header, split record, final record + CRC).
// ----------------------------------------------------------------------------
module vre_front
  import vre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       voxel_id,
  input  logic             last_voxel,
  input  logic             edited_flag,
  input  logic [7:0]       format_version,
  input  fifo_stat_t       stat,
  output logic             push,
  output cmd_t             cmd
);

  logic              header_sent, header_sent_next;
  logic [7:0]        run_symbol, run_symbol_next;
  logic [RUN_W-1:0]  run_count, run_count_next;
  logic [VCNT_W-1:0] voxel_count, voxel_count_next;
  logic              accept;
  logic              last_eff;
  logic [VCNT_W-1:0] vc_inc;

  assign s_tready = ~stat.full;
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    cmd              = '0;
    header_sent_next = header_sent;
    run_symbol_next  = run_symbol;
    run_count_next   = run_count;
    voxel_count_next = voxel_count;
    last_eff         = 1'b0;
    vc_inc           = voxel_count;

    cmd.hdr     = ~header_sent;
    cmd.version = format_version;
    cmd.edited  = edited_flag;

    if (run_count == '0) begin
      run_symbol_next = voxel_id;
      run_count_next  = RUN_W'(1);
    end else if (voxel_id == run_symbol && run_count < RUN_TOP) begin
      run_count_next = run_count + RUN_W'(1);
    end else begin
      cmd.brk         = 1'b1;
      cmd.brk_sym     = run_symbol;
      cmd.brk_len     = run_count;
      run_symbol_next = voxel_id;
      run_count_next  = RUN_W'(1);
    end

    if (voxel_count < VCNT_W'(MAX_VOXELS)) begin
      vc_inc = voxel_count + VCNT_W'(1);
    end
    last_eff = last_voxel | (vc_inc >= VCNT_W'(MAX_VOXELS));

    if (last_eff) begin
      cmd.fin          = 1'b1;
      cmd.fin_sym      = run_symbol_next;
      cmd.fin_len      = run_count_next;
      header_sent_next = 1'b0;
      run_symbol_next  = '0;
      run_count_next   = '0;
      voxel_count_next = '0;
    end else begin
      header_sent_next = 1'b1;
      voxel_count_next = vc_inc;
    end
  end

  assign push = accept & (cmd.hdr | cmd.brk | cmd.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_sent <= 1'b0;
      run_symbol  <= '0;
      run_count   <= '0;
      voxel_count <= '0;
    end else if (accept) begin
      header_sent <= header_sent_next;
      run_symbol  <= run_symbol_next;
      run_count   <= run_count_next;
      voxel_count <= voxel_count_next;
    end
  end

endmodule

FILE: sv/vre_fifo.sv
// ----------------------------------------------------------------------------
// vre_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vre_fifo
  import vre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       din,
  input  logic       pop,
  output cmd_t       dout,
  output fifo_stat_t stat
);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/vre_back.sv
// ----------------------------------------------------------------------------
// vre_back
// Walks each queued command byte by byte, keeps the CRC and stream offset,
// and drives the registered output stream.
// ----------------------------------------------------------------------------
module vre_back
  import vre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  fifo_stat_t  stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic              busy, busy_next;
  logic [STEP_W-1:0] step, step_next;
  logic [STEP_W-1:0] first, cur;
  logic [31:0]       crc_accum, crc_out;
  logic [POS_W-1:0]  write_position;
  logic              go;
  logic [7:0]        byte_val;
  logic [POS_W-1:0]  off;
  logic              patch, eos, in_crc;
  logic [1:0]        pidx;

  assign go      = ~stat.empty & (~m_tvalid | m_tready);
  assign first   = cmd.hdr ? STEP_HDR : (cmd.brk ? STEP_BRK : STEP_FIN);
  assign cur     = busy ? step : first;
  assign crc_out = crc_accum ^ CRC_ONES;
  assign pidx    = 2'(cur - STEP_PATCH);

  always_comb begin
    byte_val = 8'd0;
    off      = write_position;
    patch    = 1'b0;
    eos      = 1'b0;
    in_crc   = 1'b1;
    priority if (cur < STEP_VERSION) begin
      byte_val = MAGIC[cur[1:0]];
    end else if (cur == STEP_VERSION) begin
      byte_val = cmd.version;
    end else if (cur == STEP_FLAGS) begin
      byte_val = {7'd0, cmd.edited};
    end else if (cur <= STEP_HDR_CRC) begin
      byte_val = 8'd0;
    end else if (cur <= STEP_HDR_END) begin
      in_crc = 1'b0;
    end else if (cur == STEP_BRK) begin
      byte_val = cmd.brk_sym;
    end else if (cur == STEP_BRK + STEP_W'(1)) begin
      byte_val = cmd.brk_len[7:0];
    end else if (cur == STEP_BRK_END) begin
      byte_val = cmd.brk_len[15:8];
    end else if (cur == STEP_FIN) begin
      byte_val = cmd.fin_sym;
    end else if (cur == STEP_FIN + STEP_W'(1)) begin
      byte_val = cmd.fin_len[7:0];
    end else if (cur == STEP_FIN + STEP_W'(2)) begin
      byte_val = cmd.fin_len[15:8];
    end else begin
      byte_val = crc_out[8*pidx +: 8];
      off      = PATCH_BASE + POS_W'(pidx);
      patch    = 1'b1;
      eos      = (cur == STEP_END);
      in_crc   = 1'b0;
    end
  end

  always_comb begin
    pop       = 1'b0;
    busy_next = 1'b1;
    step_next = cur + STEP_W'(1);
    priority if (cur == STEP_HDR_END) begin
      if (cmd.brk) begin
        step_next = STEP_BRK;
      end else if (cmd.fin) begin
        step_next = STEP_FIN;
      end else begin
        pop       = go;
        busy_next = 1'b0;
      end
    end else if (cur == STEP_BRK_END) begin
      if (cmd.fin) begin
        step_next = STEP_FIN;
      end else begin
        pop       = go;
        busy_next = 1'b0;
      end
    end else if (cur == STEP_END) begin
      pop       = go;
      busy_next = 1'b0;
    end else begin
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      step           <= '0;
      crc_accum      <= CRC_ONES;
      write_position <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (go) begin
        busy     <= busy_next;
        step     <= step_next;
        m_tvalid <= 1'b1;
        if (eos) begin
          crc_accum      <= CRC_ONES;
          write_position <= '0;
        end else begin
          if (in_crc) begin
            crc_accum <= crc32_byte(crc_accum, byte_val);
          end
          if (!patch && write_position != '1) begin
            write_position <= write_position + POS_W'(1);
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {6'd0, off, byte_val};
      m_tlast <= eos;
      m_tuser <= patch;
    end
  end

endmodule

FILE: sv/voxel_rle_encoder_crc32.sv
// ----------------------------------------------------------------------------
// voxel_rle_encoder_crc32
// Run-length encoder for 8-bit voxel ids with a framed header and CRC-32.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata[7:0] voxel_id, tlast last_voxel
//   m_*      out  m_tvalid/m_tready  tdata byte+offset, tuser patch, tlast eos
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Output runs at one byte per cycle unless m_tready stalls it; a voxel emits
// 0 bytes inside a run, 3 per closed run, 12 for the header, 7 at chunk end.
// Input is taken each cycle while the 4-entry command queue has room.
// Reset is synchronous; stalls on m_tready back up through the queue.
// ----------------------------------------------------------------------------
module voxel_rle_encoder_crc32
  import vre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] voxel_id
  input  logic        s_tlast,   // last_voxel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [25:8] byte_offset, [31:26] zero
  output logic        m_tlast,   // end_of_stream
  output logic        m_tuser,   // [0] is_patch
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       edited_flag;
  logic [7:0] format_version;
  logic       push, pop;
  cmd_t       cmd_in, cmd_out;
  fifo_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      edited_flag    <= 1'b0;
      format_version <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EDITED:  edited_flag    <= cfg_data[0];
        REG_VERSION: format_version <= cfg_data;
        default: ;
      endcase
    end
  end

  vre_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .voxel_id       (s_tdata),
    .last_voxel     (s_tlast),
    .edited_flag    (edited_flag),
    .format_version (format_version),
    .stat           (stat),
    .push           (push),
    .cmd            (cmd_in)
  );

  vre_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .pop  (pop),
    .dout (cmd_out),
    .stat (stat)
  );

  vre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: sv/vre_checker.sv
// ----------------------------------------------------------------------------
// vre_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module vre_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_eos_patch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser && m_tdata[25:8] == 18'd11)
    else $error("end of stream not on last CRC byte");

  a_patch_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[25:10] == 16'd2)
    else $error("patch byte outside offsets 8 to 11");

  a_patch_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[25:8] == 18'd11 |-> m_tlast)
    else $error("last patch byte without end of stream");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:26] == 6'd0)
    else $error("nonzero tdata padding");

endmodule

bind voxel_rle_encoder_crc32 vre_checker u_vre_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

FILE: dv/voxel_rle_encoder_crc32_test.sv
// ----------------------------------------------------------------------------
// voxel_rle_encoder_crc32_test
// Self-checking bench for the voxel run-length encoder. Voxel ids go in on
// the slave stream. The bench keeps its own model of the header, run records,
// CRC-32 and patch bytes. Every output byte transfer is checked against that
// model for data, offset, patch flag and end-of-stream. Stimulus is directed
// headers, register extremes and run patterns, then random chunks under mixed
// backpressure and a long output hold-off.
// ----------------------------------------------------------------------------
module voxel_rle_encoder_crc32_test
  import vre_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 100;

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] offset;
    logic             patch;
    logic             eos;
  } enc_byte_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = REG_EDITED;
  logic [7:0]  cfg_data  = 8'd0;

  voxel_rle_encoder_crc32 u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Encoder model state
  logic             mdl_edited;
  logic [7:0]       mdl_version;
  logic             hdr_done;
  logic [7:0]       run_sym;
  logic [RUN_W-1:0] run_len;
  logic [31:0]      crc_acc;
  logic [POS_W-1:0] wr_pos;
  logic [16:0]      chunk_voxels;

  enc_byte_t   stream_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned errors       = 0;
  int unsigned voxels_sent  = 0;
  int unsigned bytes_seen   = 0;
  int unsigned chunks_done  = 0;
  int unsigned cycles       = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function void push_byte(input logic [7:0] b, input logic [POS_W-1:0] pos,
                          input logic patch, input logic eos);
    enc_byte_t e;
    e.data   = b;
    e.offset = pos;
    e.patch  = patch;
    e.eos    = eos;
    stream_q = {stream_q, e};
  endfunction

  function void stream_out(input logic [7:0] b, input logic in_crc);
    push_byte(b, wr_pos, 1'b0, 1'b0);
    if (in_crc) crc_acc = crc_update(crc_acc, b);
    if (wr_pos != {POS_W{1'b1}}) wr_pos = wr_pos + 1'b1;
  endfunction

  function void record_out(input logic [7:0] sym, input logic [RUN_W-1:0] len);
    stream_out(sym, 1'b1);
    stream_out(len[7:0], 1'b1);
    stream_out(len[15:8], 1'b1);
  endfunction

  function void clear_chunk();
    hdr_done     = 1'b0;
    run_sym      = 8'd0;
    run_len      = '0;
    crc_acc      = CRC_ONES;
    wr_pos       = '0;
    chunk_voxels = '0;
  endfunction

  function void encode_voxel(input logic [7:0] id, input logic is_last);
    logic        fin;
    logic [31:0] crc;
    fin = is_last;
    if (!hdr_done) begin
      for (int i = 0; i < 4; i++) stream_out(MAGIC[i], 1'b1);
      stream_out(mdl_version, 1'b1);
      stream_out({7'd0, mdl_edited}, 1'b1);
      stream_out(8'd0, 1'b1);
      stream_out(8'd0, 1'b1);
      for (int i = 0; i < 4; i++) stream_out(8'd0, 1'b0);
      hdr_done = 1'b1;
    end
    if (run_len == 0) begin
      run_sym = id;
      run_len = RUN_W'(1);
    end else if (id == run_sym && run_len < RUN_TOP) begin
      run_len = run_len + 1'b1;
    end else begin
      record_out(run_sym, run_len);
      run_sym = id;
      run_len = RUN_W'(1);
    end
    if (chunk_voxels < MAX_VOXELS) chunk_voxels = chunk_voxels + 1'b1;
    if (chunk_voxels >= MAX_VOXELS) fin = 1'b1;
    if (fin) begin
      record_out(run_sym, run_len);
      crc = crc_acc ^ CRC_ONES;
      for (int i = 0; i < 4; i++) begin
        push_byte(crc[8*i +: 8], PATCH_BASE + POS_W'(i), 1'b1, i == 3);
      end
      clear_chunk();
      chunks_done++;
    end
  endfunction

  always @(posedge clk) begin : check_stream
    enc_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (stream_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte transfer data=%h offset=%0d patch=%b eos=%b",
                 $time, m_tdata[7:0], m_tdata[25:8], m_tuser, m_tlast);
      end else begin
        want = stream_q.pop_front();
        bytes_seen++;
        if (m_tdata[7:0] !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h (offset %0d)",
                   $time, want.data, m_tdata[7:0], want.offset);
        end
        if (m_tdata[25:8] !== want.offset) begin
          errors++;
          $display("%0t: byte_offset expected %0d actual %0d",
                   $time, want.offset, m_tdata[25:8]);
        end
        if (m_tuser !== want.patch) begin
          errors++;
          $display("%0t: is_patch expected %b actual %b (offset %0d)",
                   $time, want.patch, m_tuser, want.offset);
        end
        if (m_tlast !== want.eos) begin
          errors++;
          $display("%0t: end_of_stream expected %b actual %b (offset %0d)",
                   $time, want.eos, m_tlast, want.offset);
        end
      end
    end
  end

  task automatic send_voxel(input logic [7:0] id, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    encode_voxel(id, is_last);
    voxels_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_EDITED) mdl_edited = val[0];
    else mdl_version = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_chunk(input int unsigned n_vox);
    logic [7:0] pal[4];
    logic [7:0] id;
    int unsigned roll;
    foreach (pal[i]) pal[i] = 8'($urandom_range(255));
    id = pal[0];
    for (int unsigned i = 0; i < n_vox; i++) begin
      roll = $urandom_range(99);
      if (roll >= 55 && roll < 90) id = pal[$urandom_range(3)];
      else if (roll >= 90) id = 8'($urandom_range(255));
      send_voxel(id, i == n_vox - 1);
    end
  endtask

  task automatic test_default_header();
    send_voxel(8'h42, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_EDITED, 8'hFF);
    write_reg(REG_VERSION, 8'hFF);
    send_voxel(8'hFF, 1'b1);
    drain();
    write_reg(REG_EDITED, 8'hFE);
    write_reg(REG_VERSION, 8'h00);
    send_voxel(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_run_patterns();
    logic [7:0] ids[9] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'hA5, 8'h01};
    foreach (ids[i]) send_voxel(ids[i], i == 8);
    send_voxel(8'h7E, 1'b0);
    send_voxel(8'h7E, 1'b1);
    drain();
  endtask

  // Register writes inside an open chunk apply from the next header on
  task automatic test_mid_chunk_write();
    send_voxel(8'h11, 1'b0);
    send_voxel(8'h11, 1'b0);
    drain();
    write_reg(REG_VERSION, 8'h80);
    write_reg(REG_EDITED, 8'h01);
    send_voxel(8'h11, 1'b0);
    send_voxel(8'h22, 1'b1);
    send_voxel(8'h33, 1'b1);
    drain();
  endtask

  task automatic test_random_chunks(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_items);
    int unsigned done_items;
    int unsigned n;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    write_reg(REG_EDITED, 8'($urandom_range(255)));
    write_reg(REG_VERSION, 8'($urandom_range(255)));
    done_items = 0;
    while (done_items < n_items) begin
      n = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
      if (n > n_items - done_items) n = n_items - done_items;
      send_chunk(n);
      done_items += n;
    end
    drain();
  endtask

  // Long output hold-off: the command queue fills and s_tready drops
  task automatic test_output_holdoff();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left    = 300;
    for (int i = 0; i < 40; i++) send_voxel(8'(i * 37), i == 39);
    drain();
  endtask

  initial begin
    mdl_edited  = 1'b0;
    mdl_version = 8'd3;
    clear_chunk();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 16;
    snk_idle_pct = 53;
    test_default_header();
    test_register_extremes();
    test_run_patterns();
    test_mid_chunk_write();
    test_random_chunks(16, 53, 125);
    test_random_chunks(53, 16, 125);
    test_random_chunks(0, 0, 121);
    test_output_holdoff();
    drain();
    $display("Checked %0d stream bytes from %0d voxels in %0d chunks", bytes_seen,
             voxels_sent, chunks_done);
    $display("Covered register extremes, mixed stalls and an output hold-off");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: voxel_rle_encoder_crc32.f
sv/vre_pkg.sv
sv/vre_front.sv
sv/vre_fifo.sv
sv/vre_back.sv
sv/voxel_rle_encoder_crc32.sv
sv/vre_checker.sv
dv/voxel_rle_encoder_crc32_test.sv
